// File: hdl/tri_rast_pkg.sv
// Types and constants shared by the triangle rasterizer modules.
// No dependencies.
package tri_rast_pkg;

  localparam int CW       = 12;          // vertex coordinate width
  localparam int DIF_W    = CW + 1;      // coordinate difference width
  localparam int NUM_W    = 2 * CW + 3;  // interpolation numerator width
  localparam int PW       = CW + 2;      // clip compare width
  localparam int SCR_W    = 12;          // screen size register width
  localparam int PIX_W    = 11;          // pixel coordinate width
  localparam int MAX_RESULTS = 64;       // pixels per input transfer

  localparam logic [0:0] CFG_SCREEN_WIDTH  = 1'b0;
  localparam logic [0:0] CFG_SCREEN_HEIGHT = 1'b1;

  typedef struct packed {
    logic signed [CW-1:0] vert0_x;
    logic signed [CW-1:0] vert0_y;
    logic signed [CW-1:0] vert1_x;
    logic signed [CW-1:0] vert1_y;
    logic signed [CW-1:0] vert2_x;
    logic signed [CW-1:0] vert2_y;
    logic        [7:0]    shade;
  } tri_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_x;
    logic [PIX_W-1:0] pixel_y;
    logic [7:0]       pixel_gray;
    logic             last_pixel;
  } pix_item_t;

  // sorted triangle as queued between front and back
  typedef struct packed {
    logic signed [CW-1:0] x0;
    logic signed [CW-1:0] y0;
    logic signed [CW-1:0] x1;
    logic signed [CW-1:0] y1;
    logic signed [CW-1:0] x2;
    logic signed [CW-1:0] y2;
    logic        [7:0]    shade;
    logic                 flat;
  } tri_t;

  typedef enum logic [3:0] {
    B_IDLE, B_MULA, B_STA, B_DIVA, B_MULB, B_STB, B_DIVB, B_SPAN, B_WALK, B_WAIT
  } back_state_t;

endpackage

// File: hdl/triangle_scanline_rasterizer_core.sv
// Top level of the scanline triangle rasterizer: config registers, front,
// queue and back. Depends on tri_rast_pkg, tri_rast_front/queue/back.
//
//   channel | signals                       | direction | accepted when
//   --------+-------------------------------+-----------+----------------------
//   tri     | tri_valid tri_stall tri_data  | in        | tri_valid & !tri_stall
//   pix     | pix_valid pix_stall pix       | out       | pix_valid & !pix_stall
//   cfg     | cfg_valid cfg_ready           | in        | cfg_valid & cfg_ready
//           | cfg_index cfg_data            |           |
//
// A triangle passes through the queue and is popped; then each row runs two
// serial edge divisions, span setup and the row exit, and walks its visible
// pixels at one per cycle unless the output stalls; off-screen rows still
// pay the setup. A transfer on tri yields at most 64 pixels; a triangle with
// more waits for further tri transfers, whose payload is ignored.
// rst is synchronous and clears all control state; pix_stall blocks the walk
// once the hold is full, and the two-entry queue lets the front accept until full.
module triangle_scanline_rasterizer_core (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    tri_valid,
  output logic                    tri_stall,
  input  tri_rast_pkg::tri_item_t tri_data,
  output logic                    pix_valid,
  input  logic                    pix_stall,
  output tri_rast_pkg::pix_item_t pix,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [0:0]              cfg_index,
  input  logic [tri_rast_pkg::SCR_W-1:0] cfg_data
);
  import tri_rast_pkg::*;

  logic [SCR_W-1:0] scr_w, scr_h;
  logic             q_full, q_nonempty, q_pop, push;
  tri_t             sorted, q_data;

  assign cfg_ready = 1'b1;

  // screen size registers
  always_ff @(posedge clk) begin
    if (rst) begin
      scr_w <= SCR_W'(600);
      scr_h <= SCR_W'(400);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SCREEN_WIDTH:  scr_w <= cfg_data;
        CFG_SCREEN_HEIGHT: scr_h <= cfg_data;
        default: ;
      endcase
    end
  end

  tri_rast_front u_front (
    .tri_in(tri_data), .full(q_full), .stall(tri_stall), .sorted(sorted)
  );

  assign push = tri_valid && !tri_stall;

  tri_rast_queue u_queue (
    .clk(clk), .rst(rst), .push(push), .wdata(sorted), .pop(q_pop),
    .full(q_full), .nonempty(q_nonempty), .rdata(q_data)
  );

  tri_rast_back u_back (
    .clk(clk), .rst(rst), .q_valid(q_nonempty), .q_data(q_data), .q_pop(q_pop),
    .scr_w(scr_w), .scr_h(scr_h),
    .pix_valid(pix_valid), .pix_stall(pix_stall), .pix(pix)
  );

endmodule

// File: hdl/tri_rast_front.sv
// Front end: takes triangles, sorts vertices by y, flags flat ones.
// Depends on tri_rast_pkg.
module tri_rast_front (
  input  tri_rast_pkg::tri_item_t tri_in,
  input  logic                    full,
  output logic                    stall,
  output tri_rast_pkg::tri_t      sorted
);
  import tri_rast_pkg::*;

  logic signed [CW-1:0] ax, ay, bx, by, cx, cy;
  logic signed [CW-1:0] t;

  always_comb begin
    t = '0;
    ax = tri_in.vert0_x; ay = tri_in.vert0_y;
    bx = tri_in.vert1_x; by = tri_in.vert1_y;
    cx = tri_in.vert2_x; cy = tri_in.vert2_y;
    if (ay > by) begin
      t = ax; ax = bx; bx = t;
      t = ay; ay = by; by = t;
    end
    if (ay > cy) begin
      t = ax; ax = cx; cx = t;
      t = ay; ay = cy; cy = t;
    end
    if (by > cy) begin
      t = bx; bx = cx; cx = t;
      t = by; by = cy; cy = t;
    end
    sorted.x0 = ax; sorted.y0 = ay;
    sorted.x1 = bx; sorted.y1 = by;
    sorted.x2 = cx; sorted.y2 = cy;
    sorted.shade = tri_in.shade;
    sorted.flat = (tri_in.vert0_y == tri_in.vert1_y) && (tri_in.vert0_y == tri_in.vert2_y);
  end

  assign stall = full;

endmodule

// File: hdl/tri_rast_queue.sv
// Two-entry queue of sorted triangles between front and back.
// Depends on tri_rast_pkg.
module tri_rast_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  tri_rast_pkg::tri_t wdata,
  input  logic               pop,
  output logic               full,
  output logic               nonempty,
  output tri_rast_pkg::tri_t rdata
);
  import tri_rast_pkg::*;

  tri_t       mem [2];
  logic       wp, rp;
  logic [1:0] count;

  assign full     = (count == 2'd2);
  assign nonempty = (count != 2'd0);
  assign rdata    = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      count <= count + 2'(push) - 2'(pop);
    end
    if (push) mem[wp] <= wdata;
  end

endmodule

// File: hdl/tri_rast_div.sv
// Iterative signed divider, one quotient bit per cycle, truncates toward zero.
// Depends on tri_rast_pkg.
module tri_rast_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic signed [tri_rast_pkg::NUM_W-1:0] dividend,
  input  logic [tri_rast_pkg::CW-1:0]   divisor,
  output logic                          done,
  output logic signed [tri_rast_pkg::CW-1:0] quotient
);
  import tri_rast_pkg::*;

  localparam int CNT_W = $clog2(NUM_W);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [NUM_W-1:0] dvd, quo, quo_s;
  logic [CW:0]      rem, rem_sh;
  logic [CW-1:0]    den;
  logic             neg, qbit;

  always_comb begin
    rem_sh = {rem[CW-1:0], dvd[NUM_W-1]};
    qbit = (rem_sh >= {1'b0, den});
    quo_s = neg ? (~quo + 1'b1) : quo;
  end

  assign quotient = signed'(quo_s[CW-1:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        den  <= divisor;
        neg  <= dividend[NUM_W-1];
        dvd  <= dividend[NUM_W-1] ? (~dividend + 1'b1) : dividend;
      end else if (busy) begin
        rem <= qbit ? (rem_sh - {1'b0, den}) : rem_sh;
        dvd <= dvd << 1;
        quo <= {quo[NUM_W-2:0], qbit};
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(NUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// File: hdl/tri_rast_back.sv
// Back end: per-row edge setup through the shared divider, then span walk,
// clipping and pixel output. Depends on tri_rast_pkg and tri_rast_div.
module tri_rast_back (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    q_valid,
  input  tri_rast_pkg::tri_t      q_data,
  output logic                    q_pop,
  input  logic [tri_rast_pkg::SCR_W-1:0] scr_w,
  input  logic [tri_rast_pkg::SCR_W-1:0] scr_h,
  output logic                    pix_valid,
  input  logic                    pix_stall,
  output tri_rast_pkg::pix_item_t pix
);
  import tri_rast_pkg::*;

  localparam int CLW = CW + 2;

  back_state_t state, state_next;

  logic signed [CW-1:0]  x0, y0, x1, y1, x2, y2;
  logic        [7:0]     shade;
  logic        [CW-1:0]  row;
  logic        [6:0]     cnt;
  logic signed [CW-1:0]  a_q, span_right;
  logic signed [CLW-1:0] column;
  logic                  hold_valid;
  pix_item_t             hold;
  logic signed [NUM_W-1:0] num_r;
  logic        [CW-1:0]  den_r;

  // edge operands
  logic signed [DIF_W-1:0] total, h1, h2, row_e;
  logic signed [DIF_W-1:0] xa, xb, nm, dn;
  logic signed [2*DIF_W-1:0] p1, p2;
  logic second, div_start, div_done;
  logic signed [CW-1:0] div_q, lo, hi;

  // walk
  logic signed [PW-1:0] yv, right, sw_m1, col_e, sr_e;
  logic row_vis, vis, slot_free, last_row, take, send;
  pix_item_t cur;

  always_comb begin
    total = DIF_W'(y2) - DIF_W'(y0);
    h1    = DIF_W'(y1) - DIF_W'(y0);
    h2    = DIF_W'(y2) - DIF_W'(y1);
    row_e = signed'({1'b0, row});
    second = (row_e > h1) || (h1 == '0);
    if (state == B_MULA) begin
      xa = DIF_W'(x0); xb = DIF_W'(x2); nm = row_e; dn = total;
    end else if (second) begin
      xa = DIF_W'(x1); xb = DIF_W'(x2); nm = row_e - h1; dn = h2;
    end else begin
      xa = DIF_W'(x0); xb = DIF_W'(x1); nm = row_e; dn = h1;
    end
    p1 = xa * dn;
    p2 = (xb - xa) * nm;
  end

  tri_rast_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(num_r), .divisor(den_r),
    .done(div_done), .quotient(div_q)
  );

  always_comb begin
    if (a_q > div_q) begin
      lo = div_q; hi = a_q;
    end else begin
      lo = a_q; hi = div_q;
    end
    yv    = PW'(y0) + signed'(PW'({1'b0, row}));
    sw_m1 = signed'(PW'({1'b0, scr_w})) - PW'(1);
    sr_e  = PW'(span_right);
    right = (sr_e > sw_m1) ? sw_m1 : sr_e;
    col_e = PW'(column);
    row_vis = (yv >= 0) && (yv < signed'(PW'({1'b0, scr_h})));
    vis = row_vis && (col_e <= right);
    slot_free = !pix_valid || !pix_stall;
    last_row = (signed'({1'b0, row + 1'b1}) >= total);
    // take: current pixel moves into hold; send: hold moves to the output
    take = (state == B_WALK) && vis && (cnt != 7'(MAX_RESULTS)) &&
           (!hold_valid || slot_free);
    send = (state == B_WALK) && hold_valid && slot_free && (vis || last_row);
    cur.pixel_x    = column[PIX_W-1:0];
    cur.pixel_y    = yv[PIX_W-1:0];
    cur.pixel_gray = shade;
    cur.last_pixel = 1'b0;
  end

  always_comb begin
    state_next = state;
    q_pop = 1'b0;
    div_start = 1'b0;
    case (state)
      B_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          if (!q_data.flat) state_next = B_MULA;
        end
      end
      B_MULA: state_next = B_STA;
      B_STA: begin
        div_start = 1'b1;
        state_next = B_DIVA;
      end
      B_DIVA: if (div_done) state_next = B_MULB;
      B_MULB: state_next = B_STB;
      B_STB: begin
        div_start = 1'b1;
        state_next = B_DIVB;
      end
      B_DIVB: if (div_done) state_next = B_SPAN;
      B_SPAN: state_next = B_WALK;
      B_WALK: begin
        if (vis) begin
          if (cnt == 7'(MAX_RESULTS) && (!hold_valid || slot_free)) state_next = B_WAIT;
        end else if (last_row) begin
          if (!hold_valid || slot_free) state_next = B_IDLE;
        end else begin
          state_next = B_MULA;
        end
      end
      B_WAIT: begin
        if (q_valid) begin
          q_pop = 1'b1;
          state_next = B_WALK;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      pix_valid <= 1'b0;
      hold_valid <= 1'b0;
      cnt <= '0;
      row <= '0;
    end else begin
      state <= state_next;
      if (send) pix_valid <= 1'b1;
      else if (slot_free) pix_valid <= 1'b0;
      if (take) hold_valid <= 1'b1;
      else if (send) hold_valid <= 1'b0;
      if (send) begin
        pix <= '{pixel_x: hold.pixel_x, pixel_y: hold.pixel_y,
                 pixel_gray: hold.pixel_gray, last_pixel: !vis};
      end
      case (state)
        B_IDLE: begin
          if (q_valid && !q_data.flat) begin
            x0 <= q_data.x0; y0 <= q_data.y0;
            x1 <= q_data.x1; y1 <= q_data.y1;
            x2 <= q_data.x2; y2 <= q_data.y2;
            shade <= q_data.shade;
            row <= '0;
            cnt <= '0;
          end
        end
        B_MULA, B_MULB: begin
          num_r <= NUM_W'(p1) + NUM_W'(p2);
          den_r <= dn[CW-1:0];
        end
        B_DIVA: if (div_done) a_q <= div_q;
        B_SPAN: begin
          span_right <= hi;
          column <= (lo < 0) ? '0 : CLW'(lo);
        end
        B_WALK: begin
          if (take) begin
            hold <= cur;
            column <= column + 1'b1;
            cnt <= cnt + 1'b1;
          end
          if (!vis && !last_row) row <= row + 1'b1;
        end
        B_WAIT: if (q_valid) cnt <= '0;
        default: ;
      endcase
    end
  end

endmodule

// File: hdl/tri_rast_checker.sv
// Port-level checks for the rasterizer top level, bound to it below.
// Depends on tri_rast_pkg.
module tri_rast_port_checks (
  input logic                    clk,
  input logic                    rst,
  input logic                    pix_valid,
  input logic                    pix_stall,
  input tri_rast_pkg::pix_item_t pix
);
  import tri_rast_pkg::*;

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    pix_valid && pix_stall |=> pix_valid) else $error("pix valid dropped");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    pix_valid && pix_stall |=> $stable(pix)) else $error("pix changed");

  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) |-> !pix_valid) else $error("pix valid after reset");

  a_gap_after_last: assert property (@(posedge clk) disable iff (rst)
    pix_valid && !pix_stall && pix.last_pixel |=> !pix_valid)
    else $error("pixel right after last");

endmodule

bind triangle_scanline_rasterizer_core tri_rast_port_checks u_chk (
  .clk(clk), .rst(rst), .pix_valid(pix_valid), .pix_stall(pix_stall), .pix(pix)
);
